>>> hdl/mbus_record_stream_parser_assert.svh
// Assertion macros for the M-Bus record stream parser.
// Included by mbrsp_parse, the module that checks its own logic; no other dependencies.
`ifndef MBUS_RECORD_STREAM_PARSER_ASSERT_SVH
`define MBUS_RECORD_STREAM_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define MBRSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define MBRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MBRSP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MBRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/mbrsp_pkg.sv
// Shared types, codes and decode tables of the M-Bus record stream parser.
// No dependencies.
`timescale 1ns / 1ps

package mbrsp_pkg;

   // Record header sizing
   localparam int MAX_EXTENSIONS = 10;
   localparam int EXT_W          = $clog2(MAX_EXTENSIONS + 1);
   localparam int STORAGE_W      = 4 * MAX_EXTENSIONS + 1;
   localparam int TARIFF_W       = 2 * MAX_EXTENSIONS;
   localparam int SUBUNIT_W      = MAX_EXTENSIONS;

   typedef logic [EXT_W-1:0] ext_count_type;
   localparam ext_count_type EXT_LIMIT = ext_count_type'(MAX_EXTENSIONS);

   // Parser phases
   typedef enum logic [5:0] {
      PH_DIF  = 6'b000001,
      PH_DIFE = 6'b000010,
      PH_VIF  = 6'b000100,
      PH_VIFE = 6'b001000,
      PH_LVAR = 6'b010000,
      PH_DATA = 6'b100000
   } phase_type;

   // Payload kinds
   localparam logic [2:0] KIND_INT      = 3'd0;
   localparam logic [2:0] KIND_FLOAT    = 3'd1;
   localparam logic [2:0] KIND_BCD_POS  = 3'd2;
   localparam logic [2:0] KIND_BCD_NEG  = 3'd3;
   localparam logic [2:0] KIND_TEXT     = 3'd4;

   // Status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_DIFE     = 3'd1;
   localparam logic [2:0] STATUS_VIF      = 3'd2;
   localparam logic [2:0] STATUS_LVAR     = 3'd3;
   localparam logic [2:0] STATUS_TRUNC    = 3'd4;

   // Data field codings
   localparam logic [3:0] CODING_NODATA   = 4'h0;
   localparam logic [3:0] CODING_REAL     = 4'h5;
   localparam logic [3:0] CODING_SELECT   = 4'h8;
   localparam logic [3:0] CODING_BCD_MIN  = 4'h9;
   localparam logic [3:0] CODING_VARIABLE = 4'hD;
   localparam logic [3:0] CODING_SPECIAL  = 4'hF;

   // VIF extension codes
   localparam logic [7:0] VIF_EXT_FB      = 8'hFB;
   localparam logic [7:0] VIF_EXT_FD      = 8'hFD;

   // LVAR ranges
   localparam logic [7:0] LVAR_TEXT_MAX   = 8'hBF;
   localparam logic [7:0] LVAR_BCD_POS    = 8'hC0;
   localparam logic [7:0] LVAR_BCD_NEG    = 8'hD0;
   localparam logic [7:0] LVAR_BCD_SPAN   = 8'd9;
   localparam logic [7:0] LVAR_BAD        = 8'hE0;
   localparam logic [7:0] LVAR_BAD_SPAN   = 8'h0F;
   localparam logic [7:0] LVAR_FLOAT      = 8'hF8;
   localparam logic [7:0] FLOAT_LEN       = 8'd4;

   // One input word
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } item_type;

   // Input register contents toward the parser
   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   // One result word
   typedef struct packed {
      logic [7:0]           payload_byte;
      logic [7:0]           payload_index;
      logic                 record_done;
      logic [2:0]           payload_kind;
      logic [STORAGE_W-1:0] storage_number;
      logic [1:0]           function_field;
      logic [TARIFF_W-1:0]  tariff_number;
      logic [SUBUNIT_W-1:0] subunit_number;
      logic [15:0]          value_info;
      logic [2:0]           status;
   } result_type;

   // Data length by coding
   function automatic logic [7:0] coding_length(input logic [3:0] coding);
      logic [7:0] len;
      case (coding)
         4'h1:    len = 8'd1;
         4'h2:    len = 8'd2;
         4'h3:    len = 8'd3;
         4'h4:    len = 8'd4;
         4'h5:    len = 8'd4;
         4'h6:    len = 8'd6;
         4'h7:    len = 8'd8;
         4'h9:    len = 8'd1;
         4'hA:    len = 8'd2;
         4'hB:    len = 8'd3;
         4'hC:    len = 8'd4;
         4'hE:    len = 8'd6;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   // Payload kind by coding
   function automatic logic [2:0] coding_kind(input logic [3:0] coding);
      logic [2:0] kind;
      if (coding == CODING_REAL) begin
         kind = KIND_FLOAT;
      end else if (coding >= CODING_BCD_MIN) begin
         kind = KIND_BCD_POS;
      end else begin
         kind = KIND_INT;
      end
      return kind;
   endfunction

   // Phase that follows the VIF(E) for a coding
   function automatic phase_type coding_phase(input logic [3:0] coding);
      phase_type ph;
      case (coding)
         CODING_NODATA:   ph = PH_DIF;
         CODING_SELECT:   ph = PH_DIF;
         CODING_SPECIAL:  ph = PH_DIF;
         CODING_VARIABLE: ph = PH_LVAR;
         default:         ph = PH_DATA;
      endcase
      return ph;
   endfunction

endpackage

>>> hdl/mbrsp_req_if.sv
// Input channel of the M-Bus record stream parser: valid/ready plus one frame byte.
// Depends on no package.
`timescale 1ns / 1ps

interface mbrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

>>> hdl/mbrsp_rsp_if.sv
// Result channel of the M-Bus record stream parser: valid/ready plus one record word.
// Depends on mbrsp_pkg for the header widths.
`timescale 1ns / 1ps

interface mbrsp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [7:0]                      payload_byte;
   logic [7:0]                      payload_index;
   logic                            record_done;
   logic [2:0]                      payload_kind;
   logic [mbrsp_pkg::STORAGE_W-1:0] storage_number;
   logic [1:0]                      function_field;
   logic [mbrsp_pkg::TARIFF_W-1:0]  tariff_number;
   logic [mbrsp_pkg::SUBUNIT_W-1:0] subunit_number;
   logic [15:0]                     value_info;
   logic [2:0]                      status;

   modport source (
      output valid, output payload_byte, output payload_index, output record_done,
      output payload_kind, output storage_number, output function_field,
      output tariff_number, output subunit_number, output value_info, output status,
      input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_index, input record_done,
      input payload_kind, input storage_number, input function_field,
      input tariff_number, input subunit_number, input value_info, input status,
      output ready
   );
endinterface

>>> hdl/mbrsp_in_reg.sv
// Input register of the M-Bus record stream parser: holds one frame byte word.
// Depends on mbrsp_pkg and mbrsp_req_if.
`timescale 1ns / 1ps

module mbrsp_in_reg (
   input  logic               clock,
   input  logic               reset,
   mbrsp_req_if.sink          req,
   input  logic               take,
   output mbrsp_pkg::slot_type slot
);

   logic                valid_ff;
   logic                valid_in;
   mbrsp_pkg::item_type item_ff;
   logic                accept;

   // Accept when empty or when the held word moves on this cycle
   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the word
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.frame_byte <= req.frame_byte;
         item_ff.frame_end  <= req.frame_end;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

>>> hdl/mbrsp_parse.sv
// Record parser of the M-Bus record stream parser: phase state, header
// accumulators and one-step decode of each byte. Depends on mbrsp_pkg.
`timescale 1ns / 1ps
`include "mbus_record_stream_parser_assert.svh"

module mbrsp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  mbrsp_pkg::slot_type   slot,
   input  logic                  room,
   output logic                  take,
   output logic                  load,
   output mbrsp_pkg::result_type result
);

   // State registers
   mbrsp_pkg::phase_type                phase_ff, phase_in;
   logic [3:0]                          coding_ff, coding_in;
   logic [mbrsp_pkg::STORAGE_W-1:0]     storage_ff, storage_in;
   logic [1:0]                          function_ff, function_in;
   logic [mbrsp_pkg::TARIFF_W-1:0]      tariff_ff, tariff_in;
   logic [mbrsp_pkg::SUBUNIT_W-1:0]     subunit_ff, subunit_in;
   mbrsp_pkg::ext_count_type            ext_ff, ext_in;
   logic [15:0]                         vi_ff, vi_in;
   logic [7:0]                          left_ff, left_in;
   logic [7:0]                          pos_ff, pos_in;
   logic [2:0]                          kind_ff, kind_in;
   logic                                halted_ff, halted_in;

   // Decode helpers
   logic [7:0]            c;
   logic                  fend;
   mbrsp_pkg::phase_type  bd_phase;
   logic [7:0]            bd_left;
   logic [2:0]            bd_kind;
   logic [7:0]            lv_n;
   logic [2:0]            lv_kind;
   logic                  lv_err;
   logic [2:0]            err;
   logic                  data_res;
   logic                  trunc;
   logic                  res_valid;
   logic                  clear;

   assign c    = slot.item.frame_byte;
   assign fend = slot.item.frame_end;
   assign take = slot.valid && room;
   assign load = take && res_valid;

   // Start of the data field, chosen by the coding of this record
   assign bd_phase = mbrsp_pkg::coding_phase(coding_ff);
   assign bd_left  = mbrsp_pkg::coding_length(coding_ff);
   assign bd_kind  = mbrsp_pkg::coding_kind(coding_ff);

   // Decode the LVAR byte
   always_comb begin
      lv_n    = 8'd0;
      lv_kind = kind_ff;
      lv_err  = 1'b0;
      if (c <= mbrsp_pkg::LVAR_TEXT_MAX) begin
         lv_n    = c;
         lv_kind = mbrsp_pkg::KIND_TEXT;
      end else if (c >= mbrsp_pkg::LVAR_BCD_POS &&
                   c <= mbrsp_pkg::LVAR_BCD_POS + mbrsp_pkg::LVAR_BCD_SPAN) begin
         lv_n    = c - mbrsp_pkg::LVAR_BCD_POS;
         lv_kind = mbrsp_pkg::KIND_BCD_POS;
      end else if (c >= mbrsp_pkg::LVAR_BCD_NEG &&
                   c <= mbrsp_pkg::LVAR_BCD_NEG + mbrsp_pkg::LVAR_BCD_SPAN) begin
         lv_n    = c - mbrsp_pkg::LVAR_BCD_NEG;
         lv_kind = mbrsp_pkg::KIND_BCD_NEG;
      end else if (c >= mbrsp_pkg::LVAR_BAD &&
                   c <= mbrsp_pkg::LVAR_BAD + mbrsp_pkg::LVAR_BAD_SPAN) begin
         lv_err  = 1'b1;
      end else if (c == mbrsp_pkg::LVAR_FLOAT) begin
         lv_n    = mbrsp_pkg::FLOAT_LEN;
         lv_kind = mbrsp_pkg::KIND_FLOAT;
      end
   end

   // Advance the parser by one byte
   always_comb begin
      phase_in    = phase_ff;
      coding_in   = coding_ff;
      storage_in  = storage_ff;
      function_in = function_ff;
      tariff_in   = tariff_ff;
      subunit_in  = subunit_ff;
      ext_in      = ext_ff;
      vi_in       = vi_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      err         = mbrsp_pkg::STATUS_OK;
      data_res    = 1'b0;
      case (phase_ff)
         mbrsp_pkg::PH_DIF: begin
            coding_in   = c[3:0];
            function_in = c[5:4];
            storage_in  = mbrsp_pkg::STORAGE_W'(c[6]);
            tariff_in   = '0;
            subunit_in  = '0;
            ext_in      = '0;
            vi_in       = '0;
            left_in     = '0;
            pos_in      = '0;
            kind_in     = mbrsp_pkg::KIND_INT;
            phase_in    = c[7] ? mbrsp_pkg::PH_DIFE : mbrsp_pkg::PH_VIF;
         end
         mbrsp_pkg::PH_DIFE: begin
            // Merge this DIFE into the slot given by the extension count
            for (int i = 0; i < mbrsp_pkg::MAX_EXTENSIONS; i++) begin
               if (ext_ff == mbrsp_pkg::ext_count_type'(i)) begin
                  storage_in[4*i+1 +: 4] = storage_ff[4*i+1 +: 4] | c[3:0];
                  tariff_in[2*i +: 2]    = tariff_ff[2*i +: 2] | c[5:4];
                  subunit_in[i]          = subunit_ff[i] | c[6];
               end
            end
            if (c[7]) begin
               ext_in = mbrsp_pkg::ext_count_type'(ext_ff + 1'b1);
               if (ext_in >= mbrsp_pkg::EXT_LIMIT) begin
                  err = mbrsp_pkg::STATUS_DIFE;
               end
            end else begin
               phase_in = mbrsp_pkg::PH_VIF;
            end
         end
         mbrsp_pkg::PH_VIF: begin
            vi_in = {8'h00, c};
            if (c[7]) begin
               if (c == mbrsp_pkg::VIF_EXT_FB || c == mbrsp_pkg::VIF_EXT_FD) begin
                  phase_in = mbrsp_pkg::PH_VIFE;
               end else begin
                  err = mbrsp_pkg::STATUS_VIF;
               end
            end else begin
               phase_in = bd_phase;
               if (bd_phase == mbrsp_pkg::PH_DATA) begin
                  left_in = bd_left;
                  kind_in = bd_kind;
                  pos_in  = '0;
               end
            end
         end
         mbrsp_pkg::PH_VIFE: begin
            vi_in    = {vi_ff[7:0], c};
            phase_in = bd_phase;
            if (bd_phase == mbrsp_pkg::PH_DATA) begin
               left_in = bd_left;
               kind_in = bd_kind;
               pos_in  = '0;
            end
         end
         mbrsp_pkg::PH_LVAR: begin
            if (lv_err) begin
               err = mbrsp_pkg::STATUS_LVAR;
            end else begin
               kind_in = lv_kind;
               pos_in  = '0;
               if (lv_n == 8'd0) begin
                  phase_in = mbrsp_pkg::PH_DIF;
               end else begin
                  left_in  = lv_n;
                  phase_in = mbrsp_pkg::PH_DATA;
               end
            end
         end
         mbrsp_pkg::PH_DATA: begin
            data_res = 1'b1;
            pos_in   = pos_ff + 8'd1;
            if (left_ff <= 8'd1) begin
               left_in  = '0;
               phase_in = mbrsp_pkg::PH_DIF;
            end else begin
               left_in  = left_ff - 8'd1;
            end
         end
         default: begin
            phase_in = mbrsp_pkg::PH_DIF;
         end
      endcase
      halted_in = (err != mbrsp_pkg::STATUS_OK);
   end

   // Frame ends inside a record
   assign trunc     = fend && (phase_in != mbrsp_pkg::PH_DIF) &&
                      (err == mbrsp_pkg::STATUS_OK);
   assign res_valid = !halted_ff && (data_res || trunc || err != mbrsp_pkg::STATUS_OK);

   // Build the result word from the updated header
   always_comb begin
      result.payload_byte   = data_res ? c : 8'd0;
      result.payload_index  = data_res ? pos_ff : 8'd0;
      result.record_done    = data_res ? (left_ff <= 8'd1 || trunc) : 1'b1;
      result.payload_kind   = data_res ? kind_ff : mbrsp_pkg::KIND_INT;
      result.storage_number = storage_in;
      result.function_field = function_in;
      result.tariff_number  = tariff_in;
      result.subunit_number = subunit_in;
      result.value_info     = vi_in;
      if (err != mbrsp_pkg::STATUS_OK) begin
         result.status = err;
      end else if (trunc) begin
         result.status = mbrsp_pkg::STATUS_TRUNC;
      end else begin
         result.status = mbrsp_pkg::STATUS_OK;
      end
   end

   // Drop all record state at reset and after the last byte of a frame
   assign clear = reset || (take && fend);

   always_ff @(posedge clock) begin
      if (clear) begin
         phase_ff    <= mbrsp_pkg::PH_DIF;
         coding_ff   <= '0;
         storage_ff  <= '0;
         function_ff <= '0;
         tariff_ff   <= '0;
         subunit_ff  <= '0;
         ext_ff      <= '0;
         vi_ff       <= '0;
         left_ff     <= '0;
         pos_ff      <= '0;
         kind_ff     <= mbrsp_pkg::KIND_INT;
         halted_ff   <= 1'b0;
      end else if (take && !halted_ff) begin
         phase_ff    <= phase_in;
         coding_ff   <= coding_in;
         storage_ff  <= storage_in;
         function_ff <= function_in;
         tariff_ff   <= tariff_in;
         subunit_ff  <= subunit_in;
         ext_ff      <= ext_in;
         vi_ff       <= vi_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
         halted_ff   <= halted_in;
      end
   end

   // Checks
   `MBRSP_ASSERT_NOW(a_halt_silent, clock, reset, halted_ff && take, !load, "result while halted")
   `MBRSP_ASSERT_NEXT(a_end_clears, clock, reset, take && fend, phase_ff == mbrsp_pkg::PH_DIF && !halted_ff, "state kept after frame end")
   `MBRSP_ASSERT_NOW(a_data_len, clock, reset, phase_ff == mbrsp_pkg::PH_DATA, left_ff != 8'd0, "data phase with no bytes left")
   `MBRSP_ASSERT_NEXT(a_err_halts, clock, reset, load && !fend && (result.status == mbrsp_pkg::STATUS_DIFE || result.status == mbrsp_pkg::STATUS_VIF || result.status == mbrsp_pkg::STATUS_LVAR), halted_ff, "error did not halt")

endmodule

>>> hdl/mbrsp_out_reg.sv
// Result register of the M-Bus record stream parser: holds one result word
// until the receiver takes it. Depends on mbrsp_pkg and mbrsp_rsp_if.
`timescale 1ns / 1ps

module mbrsp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mbrsp_pkg::result_type result,
   output logic                  room,
   mbrsp_rsp_if.source           rsp
);

   logic                  valid_ff;
   logic                  valid_in;
   mbrsp_pkg::result_type res_ff;

   // Free when empty or when the held word leaves this cycle
   assign room = !valid_ff || rsp.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.payload_byte   = res_ff.payload_byte;
   assign rsp.payload_index  = res_ff.payload_index;
   assign rsp.record_done    = res_ff.record_done;
   assign rsp.payload_kind   = res_ff.payload_kind;
   assign rsp.storage_number = res_ff.storage_number;
   assign rsp.function_field = res_ff.function_field;
   assign rsp.tariff_number  = res_ff.tariff_number;
   assign rsp.subunit_number = res_ff.subunit_number;
   assign rsp.value_info     = res_ff.value_info;
   assign rsp.status         = res_ff.status;

endmodule

>>> hdl/mbus_record_stream_parser.sv
// M-Bus data record stream parser, top level.
// Bytes of a frame's record area enter on req_chan, one word per byte, with
// frame_end set on the last byte of the frame. For every data byte of a
// record one word leaves on rsp_chan with the record header (storage,
// function, tariff, subunit, VIF/VIFE), the byte's index and its kind.
// Header bytes produce no word unless the frame ends inside a record's header. An error
// gives one header-only word with a nonzero status; bytes are then dropped
// until the byte with frame_end. A byte in the input register is decoded and
// its result word loaded into the result register. Throughput: one byte per
// cycle unless rsp_chan stalls; the per-byte decode is a single short step.
// Reset (synchronous) empties both registers and returns the parser to
// expect a DIF. When rsp_chan stalls, the result register holds its word,
// one more byte waits in the input register, and req_chan.ready drops.
// Depends on mbrsp_pkg, mbrsp_req_if, mbrsp_rsp_if and the three stages.
`timescale 1ns / 1ps

module mbus_record_stream_parser (
   input  logic        clock,
   input  logic        reset,
   mbrsp_req_if.sink   req_chan,
   mbrsp_rsp_if.source rsp_chan
);

   mbrsp_pkg::slot_type   slot;
   mbrsp_pkg::result_type result;
   logic                  take;
   logic                  load;
   logic                  room;

   mbrsp_in_reg u_in_reg (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .take  (take),
      .slot  (slot)
   );

   mbrsp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .slot   (slot),
      .room   (room),
      .take   (take),
      .load   (load),
      .result (result)
   );

   mbrsp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .result (result),
      .room   (room),
      .rsp    (rsp_chan)
   );

endmodule
